FILE: sv/mst_pkg.sv
package mst_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int MAX_REPORTS   = 16;
	localparam int REP_CNT_W     = $clog2(MAX_REPORTS + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [15:0] EV_SYNC     = 16'd0;
	localparam logic [15:0] EV_ABS      = 16'd3;
	localparam logic [15:0] CODE_REPORT = 16'h0000;
	localparam logic [15:0] CODE_SLOT   = 16'h002f;
	localparam logic [15:0] CODE_POS_X  = 16'h0035;
	localparam logic [15:0] CODE_POS_Y  = 16'h0036;
	localparam logic [15:0] CODE_TRACK  = 16'h0039;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DOWN = 2'd1;
	localparam logic [1:0] PH_MOVE = 2'd2;
	localparam logic [1:0] PH_UP   = 2'd3;

	localparam logic [1:0] TS_DOWN = 2'd0;
	localparam logic [1:0] TS_MOVE = 2'd1;
	localparam logic [1:0] TS_UP   = 2'd2;

	localparam logic [2:0] ROT_NONE = 3'd0;
	localparam logic [2:0] ROT_90   = 3'd1;
	localparam logic [2:0] ROT_180  = 3'd2;
	localparam logic [2:0] ROT_270  = 3'd3;
	localparam logic [2:0] ROT_ANY  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_ROT_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPAN_W   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPAN_H   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_COS      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SIN      = 3'd6;

	localparam int VB_X  = 0;
	localparam int VB_Y  = 1;
	localparam int VB_LX = 2;
	localparam int VB_LY = 3;

	typedef struct packed {
		logic [2:0]         rot_mode;
		logic [15:0]        x_origin;
		logic [15:0]        y_origin;
		logic [16:0]        span_w;
		logic [16:0]        span_h;
		logic signed [15:0] cos_q14;
		logic signed [15:0] sin_q14;
	} mst_cfg_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic [30:0] contact;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] last_x;
		logic [15:0] last_y;
		logic [3:0]  vb;
	} slot_rec_t;

	typedef struct packed {
		logic [3:0]  slot;
		logic [30:0] contact;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic        has_x;
		logic        has_y;
		logic [1:0]  state;
		logic        last;
	} report_t;

endpackage

FILE: sv/mst_ram.sv
module mst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/mst_rotate.sv
module mst_rotate
	import mst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  mst_cfg_t    cfg,
	input  logic        in_valid,
	input  report_t     in_rep,
	output logic        ready,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  out_slot,
	output logic [30:0] out_contact,
	output logic [15:0] out_x,
	output logic [15:0] out_y,
	output logic [1:0]  out_state,
	output logic        out_last
);

	function automatic logic [15:0] span_m1(input logic [16:0] s);
		logic [15:0] r;
		if (s == 17'd0) begin
			r = 16'd0;
		end else if (s[16]) begin
			r = 16'hffff;
		end else begin
			r = s[15:0] - 16'd1;
		end
		return r;
	endfunction

	function automatic logic [15:0] sat_s19(input logic signed [18:0] v);
		logic [15:0] r;
		if (v[18]) begin
			r = 16'd0;
		end else if (v > 19'sd65535) begin
			r = 16'hffff;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Q15 rounding half away from zero, then clamp to 0..hi.
	function automatic logic [15:0] round_clamp(input logic signed [35:0] n,
			input logic [15:0] hi);
		logic signed [35:0] t;
		logic signed [35:0] r;
		logic [15:0]        o;
		t = n + (n[35] ? 36'sd16383 : 36'sd16384);
		r = t >>> 15;
		if (r[35]) begin
			o = 16'd0;
		end else if (r > $signed({20'd0, hi})) begin
			o = hi;
		end else begin
			o = r[15:0];
		end
		return o;
	endfunction

	logic [15:0]        w1, h1;
	logic signed [18:0] w1s, h1s, xo, yo, rx, ry, dx2, dy2;
	logic               adv;

	logic               v_s1, v_s2, v_s3, v_s4;
	report_t            rep_s1, rep_s2, rep_s3, rep_s4;
	logic               gen_s1, gen_s2, gen_s3;
	logic signed [18:0] rx_s1, ry_s1, rx_s2, ry_s2, rx_s3, ry_s3;
	logic signed [18:0] dx2_s1, dy2_s1;
	logic signed [34:0] pxc_s2, pys_s2, pxs_s2, pyc_s2;
	logic signed [35:0] nx_s3, ny_s3;
	logic [15:0]        x_s4, y_s4;
	logic [15:0]        xf, yf;

	assign w1  = span_m1(cfg.span_w);
	assign h1  = span_m1(cfg.span_h);
	assign w1s = $signed({3'b000, w1});
	assign h1s = $signed({3'b000, h1});
	assign adv = !v_s4 || !out_stall;
	assign ready = adv;

	always_comb begin
		xo  = $signed({3'b000, in_rep.pos_x}) - $signed({3'b000, cfg.x_origin});
		yo  = $signed({3'b000, in_rep.pos_y}) - $signed({3'b000, cfg.y_origin});
		dx2 = $signed({xo[17:0], 1'b0}) - w1s;
		dy2 = $signed({yo[17:0], 1'b0}) - h1s;
		case (cfg.rot_mode)
			ROT_90: begin
				rx = h1s - yo;
				ry = xo;
			end
			ROT_180: begin
				rx = w1s - xo;
				ry = h1s - yo;
			end
			ROT_270: begin
				rx = yo;
				ry = w1s - xo;
			end
			default: begin
				rx = xo;
				ry = yo;
			end
		endcase
	end

	always_comb begin
		if (gen_s3) begin
			xf = round_clamp(nx_s3, w1);
			yf = round_clamp(ny_s3, h1);
		end else begin
			xf = sat_s19(rx_s3);
			yf = sat_s19(ry_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rep_s1 <= in_rep;
			gen_s1 <= (cfg.rot_mode == ROT_ANY);
			rx_s1  <= rx;
			ry_s1  <= ry;
			dx2_s1 <= dx2;
			dy2_s1 <= dy2;

			rep_s2 <= rep_s1;
			gen_s2 <= gen_s1;
			rx_s2  <= rx_s1;
			ry_s2  <= ry_s1;
			pxc_s2 <= 35'(dx2_s1) * 35'(cfg.cos_q14);
			pys_s2 <= 35'(dy2_s1) * 35'(cfg.sin_q14);
			pxs_s2 <= 35'(dx2_s1) * 35'(cfg.sin_q14);
			pyc_s2 <= 35'(dy2_s1) * 35'(cfg.cos_q14);

			rep_s3 <= rep_s2;
			gen_s3 <= gen_s2;
			rx_s3  <= rx_s2;
			ry_s3  <= ry_s2;
			nx_s3  <= 36'(pxc_s2) + 36'(pys_s2) + $signed({6'd0, w1, 14'd0});
			ny_s3  <= 36'(pyc_s2) - 36'(pxs_s2) + $signed({6'd0, h1, 14'd0});

			rep_s4 <= rep_s3;
			x_s4   <= rep_s3.has_x ? xf : 16'd0;
			y_s4   <= rep_s3.has_y ? yf : 16'd0;
		end
	end

	assign out_valid   = v_s4;
	assign out_slot    = rep_s4.slot;
	assign out_contact = rep_s4.contact;
	assign out_x       = x_s4;
	assign out_y       = y_s4;
	assign out_state   = rep_s4.state;
	assign out_last    = rep_s4.last;

endmodule

FILE: sv/multitouch_slot_tracker.sv
// Channel  Dir  Handshake                    Word
// event    in   event_valid / event_stall    event_type, event_code, event_value
// report   out  report_valid / report_stall  slot_index, contact_id, x_out, y_out,
//                                            touch_state, last_report
// config   in   cfg_write_en                 cfg_index, cfg_data
//
// A slot select or an ignored event is taken while idle; a tracking-id or position event
// also reads and writes back the slot record in the dual-port slot RAM.
// On a sync report the walk reads one slot record per cycle unless a held report stalls it.
// Each report then passes a four-stage rotation pipeline before it shows on the port.
// Reset clears the per-slot written flags, so no clearing pass runs after reset.
// A stalled report holds the rotation pipeline, and then the walk.
module multitouch_slot_tracker
	import mst_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  event_valid,
	output logic                  event_stall,
	input  logic [15:0]           event_type,
	input  logic [15:0]           event_code,
	input  logic signed [31:0]    event_value,
	output logic                  report_valid,
	input  logic                  report_stall,
	output logic [3:0]            slot_index,
	output logic [30:0]           contact_id,
	output logic [15:0]           x_out,
	output logic [15:0]           y_out,
	output logic [1:0]            touch_state,
	output logic                  last_report
);

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int IDX_W  = $clog2(NUM_SLOTS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_AXIS, ST_WALK, ST_FLUSH} state_t;

	function automatic logic [15:0] sat16(input logic signed [31:0] v);
		logic [15:0] r;
		if (v[31]) begin
			r = 16'd0;
		end else if (v > 32'sd65535) begin
			r = 16'hffff;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	state_t               state_q;
	mst_cfg_t             cfg_q;
	logic [SLOT_W-1:0]    cur_slot_q;
	logic                 sel_ok_q;
	logic [15:0]          ax_code_q;
	logic signed [31:0]   ax_value_q;
	logic [NUM_SLOTS-1:0] written_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic                 eval_v_s1;
	logic [SLOT_W-1:0]    eval_idx_s1;
	logic [REP_CNT_W-1:0] rep_cnt_q;
	logic                 pend_v_q;
	report_t              pend_q;

	logic                 ev_acc, is_slot, is_axis, is_sync, slot_ok;
	logic [SLOT_W-1:0]    rec_addr, ram_raddr, ram_waddr;
	logic                 ram_we;
	logic [$bits(slot_rec_t)-1:0] ram_rdata;
	slot_rec_t            rec, upd, wrec;
	logic [15:0]          ax_sat;
	logic                 emit, hold, walk_go, issue;
	logic [1:0]           rep_state;
	report_t              new_rep, rot_rep;
	logic [REP_CNT_W-1:0] cnt_next;
	logic                 rot_valid, rot_ready;

	assign event_stall = (state_q != ST_IDLE);
	assign ev_acc  = event_valid && !event_stall;
	assign is_slot = (event_type == EV_ABS) && (event_code == CODE_SLOT);
	assign is_axis = (event_type == EV_ABS) && sel_ok_q
		&& (event_code == CODE_TRACK || event_code == CODE_POS_X || event_code == CODE_POS_Y);
	assign is_sync = (event_type == EV_SYNC) && (event_code == CODE_REPORT);
	assign slot_ok = $unsigned(event_value) < $unsigned(32'(NUM_SLOTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_mode <= ROT_NONE;
			cfg_q.x_origin <= 16'd0;
			cfg_q.y_origin <= 16'd0;
			cfg_q.span_w   <= 17'd4096;
			cfg_q.span_h   <= 17'd4096;
			cfg_q.cos_q14  <= 16'sd16384;
			cfg_q.sin_q14  <= 16'sd0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_ROT_MODE: cfg_q.rot_mode <= cfg_data[2:0];
				CFG_X_ORIGIN: cfg_q.x_origin <= cfg_data[15:0];
				CFG_Y_ORIGIN: cfg_q.y_origin <= cfg_data[15:0];
				CFG_SPAN_W:   cfg_q.span_w   <= cfg_data;
				CFG_SPAN_H:   cfg_q.span_h   <= cfg_data;
				CFG_COS:      cfg_q.cos_q14  <= $signed(cfg_data[15:0]);
				CFG_SIN:      cfg_q.sin_q14  <= $signed(cfg_data[15:0]);
				default: ;
			endcase
		end
	end

	// A slot that was never written reads as idle with no axes received.
	assign rec_addr = (state_q == ST_AXIS) ? cur_slot_q : eval_idx_s1;
	assign rec      = written_q[rec_addr] ? slot_rec_t'(ram_rdata) : '0;
	assign ax_sat   = sat16(ax_value_q);

	always_comb begin
		upd = rec;
		case (ax_code_q)
			CODE_TRACK: begin
				if (!ax_value_q[31]) begin
					upd         = '0;
					upd.contact = ax_value_q[30:0];
					upd.phase   = PH_DOWN;
				end else if (rec.phase != PH_IDLE) begin
					upd.phase = PH_UP;
				end
			end
			CODE_POS_X: begin
				upd.pos_x     = ax_sat;
				upd.vb[VB_X]  = 1'b1;
				if (!rec.vb[VB_LX]) begin
					upd.last_x    = ax_sat;
					upd.vb[VB_LX] = 1'b1;
				end
			end
			CODE_POS_Y: begin
				upd.pos_y     = ax_sat;
				upd.vb[VB_Y]  = 1'b1;
				if (!rec.vb[VB_LY]) begin
					upd.last_y    = ax_sat;
					upd.vb[VB_LY] = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		wrec      = rec;
		emit      = 1'b0;
		rep_state = TS_DOWN;
		case (rec.phase)
			PH_UP: begin
				emit       = 1'b1;
				rep_state  = TS_UP;
				wrec.phase = PH_IDLE;
				wrec.vb    = 4'd0;
			end
			PH_DOWN: begin
				if (rec.vb[VB_X] && rec.vb[VB_Y]) begin
					emit       = 1'b1;
					rep_state  = TS_DOWN;
					wrec.phase = PH_MOVE;
				end
			end
			PH_MOVE: begin
				if ({rec.pos_x, rec.pos_y} != {rec.last_x, rec.last_y}) begin
					emit        = 1'b1;
					rep_state   = TS_MOVE;
					wrec.last_x = rec.pos_x;
					wrec.last_y = rec.pos_y;
				end
			end
			default: ;
		endcase
		emit = emit && eval_v_s1;
	end

	always_comb begin
		new_rep.slot    = 4'(eval_idx_s1);
		new_rep.contact = rec.contact;
		new_rep.pos_x   = rec.pos_x;
		new_rep.pos_y   = rec.pos_y;
		new_rep.has_x   = rec.vb[VB_X];
		new_rep.has_y   = rec.vb[VB_Y];
		new_rep.state   = rep_state;
		new_rep.last    = 1'b0;
		rot_rep         = pend_q;
		rot_rep.last    = (state_q == ST_FLUSH);
	end

	assign hold      = emit && pend_v_q && !rot_ready;
	assign walk_go   = (state_q == ST_WALK) && !hold;
	assign cnt_next  = rep_cnt_q + REP_CNT_W'(emit);
	assign issue     = walk_go && (rd_idx_q != IDX_W'(NUM_SLOTS))
		&& (cnt_next < REP_CNT_W'(MAX_REPORTS));
	assign rot_valid = ((state_q == ST_WALK) && emit && pend_v_q)
		|| ((state_q == ST_FLUSH) && pend_v_q);

	always_comb begin
		ram_raddr = cur_slot_q;
		case (state_q)
			ST_IDLE: ram_raddr = is_sync ? '0 : cur_slot_q;
			ST_WALK: ram_raddr = hold ? eval_idx_s1 : rd_idx_q[SLOT_W-1:0];
			default: ram_raddr = cur_slot_q;
		endcase
	end

	assign ram_we    = (state_q == ST_AXIS) || (walk_go && emit);
	assign ram_waddr = (state_q == ST_AXIS) ? cur_slot_q : eval_idx_s1;

	mst_ram #(
		.WIDTH ($bits(slot_rec_t)),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ((state_q == ST_AXIS) ? upd : wrec),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (ram_we) begin
			written_q[ram_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_slot_q  <= '0;
			sel_ok_q    <= 1'b1;
			rd_idx_q    <= '0;
			eval_v_s1   <= 1'b0;
			eval_idx_s1 <= '0;
			rep_cnt_q   <= '0;
			pend_v_q    <= 1'b0;
			pend_q      <= '0;
			ax_code_q   <= CODE_REPORT;
			ax_value_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ev_acc) begin
						if (is_slot) begin
							sel_ok_q <= slot_ok;
							if (slot_ok) begin
								cur_slot_q <= event_value[SLOT_W-1:0];
							end
						end else if (is_axis) begin
							ax_code_q  <= event_code;
							ax_value_q <= event_value;
							state_q    <= ST_AXIS;
						end else if (is_sync) begin
							rd_idx_q    <= IDX_W'(1);
							eval_v_s1   <= 1'b1;
							eval_idx_s1 <= '0;
							rep_cnt_q   <= '0;
							state_q     <= ST_WALK;
						end
					end
				end
				ST_AXIS: begin
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					if (walk_go) begin
						rep_cnt_q <= cnt_next;
						if (emit) begin
							pend_q   <= new_rep;
							pend_v_q <= 1'b1;
						end
						if (issue) begin
							eval_v_s1   <= 1'b1;
							eval_idx_s1 <= rd_idx_q[SLOT_W-1:0];
							rd_idx_q    <= rd_idx_q + IDX_W'(1);
						end else begin
							eval_v_s1 <= 1'b0;
							state_q   <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (rot_ready) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	mst_rotate u_rotate (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (rot_valid),
		.in_rep      (rot_rep),
		.ready       (rot_ready),
		.out_valid   (report_valid),
		.out_stall   (report_stall),
		.out_slot    (slot_index),
		.out_contact (contact_id),
		.out_x       (x_out),
		.out_y       (y_out),
		.out_state   (touch_state),
		.out_last    (last_report)
	);

	a_eval_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		eval_v_s1 |-> ($unsigned(32'(eval_idx_s1)) < $unsigned(32'(NUM_SLOTS))))
		else $error("Walk evaluates a slot beyond the slot count.");

	a_report_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rep_cnt_q <= REP_CNT_W'(MAX_REPORTS))
		else $error("More reports than allowed in one sync.");

	a_pend_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (state_q == ST_WALK || state_q == ST_FLUSH))
		else $error("A pending report is left behind after the walk.");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == ST_WALK) |-> (ram_raddr != ram_waddr))
		else $error("Walk reads the slot record it writes back.");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mst_pkg::*;

	localparam int SLOTS      = NUM_SLOTS_DEF;
	localparam int LONG_HOLD  = 400;
	localparam int SETTLE     = 40;
	localparam int TIMEOUT_NS = 10_000_000;

	typedef struct packed {
		logic [15:0] etype;
		logic [15:0] code;
		logic [31:0] value;
	} ev_word_t;

	typedef struct packed {
		logic [3:0]  slot;
		logic [30:0] id;
		logic [15:0] x;
		logic [15:0] y;
		logic [1:0]  state;
		logic        last;
	} touch_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  event_valid = 1'b0;
	logic                  event_stall;
	logic [15:0]           event_type = '0;
	logic [15:0]           event_code = '0;
	logic signed [31:0]    event_value = '0;
	logic                  report_valid;
	logic                  report_stall = 1'b0;
	logic [3:0]            slot_index;
	logic [30:0]           contact_id;
	logic [15:0]           x_out;
	logic [15:0]           y_out;
	logic [1:0]            touch_state;
	logic                  last_report;

	multitouch_slot_tracker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.event_type   (event_type),
		.event_code   (event_code),
		.event_value  (event_value),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.slot_index   (slot_index),
		.contact_id   (contact_id),
		.x_out        (x_out),
		.y_out        (y_out),
		.touch_state  (touch_state),
		.last_report  (last_report)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Tracker copy: register settings and per-slot contact records.
	logic [2:0]         rot_mode = ROT_NONE;
	logic [15:0]        x_org = '0;
	logic [15:0]        y_org = '0;
	logic [16:0]        span_w = 17'd4096;
	logic [16:0]        span_h = 17'd4096;
	logic signed [15:0] cos_q = 16'sd16384;
	logic signed [15:0] sin_q = '0;

	int         sel_slot = 0;
	bit         sel_ok = 1'b1;
	bit [1:0]   phase [SLOTS];
	bit [30:0]  contact [SLOTS];
	bit [15:0]  pos_x [SLOTS];
	bit [15:0]  pos_y [SLOTS];
	bit [15:0]  last_x [SLOTS];
	bit [15:0]  last_y [SLOTS];
	bit [3:0]   seen [SLOTS];

	ev_word_t      queued_events [$];
	touch_report_t expected_reports [$];

	// Generator view of the slot selection, so positions only reach slots that have been given a contact id.
	int  gen_slot = 0;
	bit  gen_sel = 1'b1;
	bit  touched [SLOTS];

	bit  idle_on = 1'b1;
	bit  hold_req = 1'b0;
	int  tx_wait = 0;
	int  rx_wait = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	int  errors = 0;
	int  reports_seen = 0;
	int  n_items = 0;
	int  n_noise = 0;
	int  n_settings = 1;

	function automatic longint clip_to(longint v, longint hi);
		return v < 0 ? 0 : (v > hi ? hi : v);
	endfunction

	function automatic longint span_len(logic [16:0] s);
		if (s == 0)
			return 1;
		if (s > 17'd65536)
			return 65536;
		return longint'(s);
	endfunction

	function automatic longint round_q15(longint n);
		if (n >= 0)
			return (n + 16384) / 32768;
		return -((-n + 16384) / 32768);
	endfunction

	function automatic void rotate_point(input logic [15:0] px, input logic [15:0] py,
			output logic [15:0] ox, output logic [15:0] oy);
		longint x, y, xo, yo, w, h, cq, sq, xr, yr, dx2, dy2, nx, ny;
		x = longint'(px);
		y = longint'(py);
		xo = longint'(x_org);
		yo = longint'(y_org);
		x = x - xo;
		y = y - yo;
		w = span_len(span_w);
		h = span_len(span_h);
		cq = longint'(cos_q);
		sq = longint'(sin_q);
		xr = x;
		yr = y;
		case (rot_mode)
			ROT_90: begin
				xr = (h - 1) - y;
				yr = x;
			end
			ROT_180: begin
				xr = (w - 1) - x;
				yr = (h - 1) - y;
			end
			ROT_270: begin
				xr = y;
				yr = (w - 1) - x;
			end
			ROT_ANY: begin
				dx2 = 2 * x - (w - 1);
				dy2 = 2 * y - (h - 1);
				nx = dx2 * cq + dy2 * sq + (w - 1) * 16384;
				ny = -dx2 * sq + dy2 * cq + (h - 1) * 16384;
				xr = clip_to(round_q15(nx), w - 1);
				yr = clip_to(round_q15(ny), h - 1);
			end
			default: ;
		endcase
		ox = 16'(clip_to(xr, 65535));
		oy = 16'(clip_to(yr, 65535));
	endfunction

	function automatic void apply_event(input logic [15:0] t, input logic [15:0] c,
			input logic signed [31:0] v);
		longint        val;
		int            s, n;
		bit            emit;
		touch_report_t r, held;
		logic [15:0]   rx, ry;
		val = longint'(v);
		n = 0;
		held = '0;
		if (t == EV_ABS) begin
			if (c == CODE_SLOT) begin
				sel_ok = (val >= 0 && val < SLOTS);
				if (sel_ok)
					sel_slot = int'(val);
				return;
			end
			if (!sel_ok)
				return;
			s = sel_slot;
			if (c == CODE_TRACK) begin
				if (val >= 0) begin
					contact[s] = v[30:0];
					phase[s] = PH_DOWN;
					seen[s] = '0;
					pos_x[s] = '0;
					pos_y[s] = '0;
					last_x[s] = '0;
					last_y[s] = '0;
				end else if (phase[s] != PH_IDLE) begin
					phase[s] = PH_UP;
				end
			end else if (c == CODE_POS_X) begin
				pos_x[s] = 16'(clip_to(val, 65535));
				seen[s][VB_X] = 1'b1;
				if (!seen[s][VB_LX]) begin
					last_x[s] = pos_x[s];
					seen[s][VB_LX] = 1'b1;
				end
			end else if (c == CODE_POS_Y) begin
				pos_y[s] = 16'(clip_to(val, 65535));
				seen[s][VB_Y] = 1'b1;
				if (!seen[s][VB_LY]) begin
					last_y[s] = pos_y[s];
					seen[s][VB_LY] = 1'b1;
				end
			end
			return;
		end
		if (t != EV_SYNC || c != CODE_REPORT)
			return;
		for (s = 0; s < SLOTS && n < MAX_REPORTS; s++) begin
			rotate_point(pos_x[s], pos_y[s], rx, ry);
			r.slot = 4'(s);
			r.id = contact[s];
			r.x = seen[s][VB_X] ? rx : 16'd0;
			r.y = seen[s][VB_Y] ? ry : 16'd0;
			r.state = TS_DOWN;
			r.last = 1'b0;
			emit = 1'b0;
			if (phase[s] == PH_UP) begin
				emit = 1'b1;
				r.state = TS_UP;
				phase[s] = PH_IDLE;
				seen[s] = '0;
			end else if (phase[s] == PH_DOWN) begin
				if (seen[s][VB_X] && seen[s][VB_Y]) begin
					emit = 1'b1;
					r.state = TS_DOWN;
					phase[s] = PH_MOVE;
				end
			end else if (phase[s] == PH_MOVE &&
					(pos_x[s] != last_x[s] || pos_y[s] != last_y[s])) begin
				emit = 1'b1;
				r.state = TS_MOVE;
				last_x[s] = pos_x[s];
				last_y[s] = pos_y[s];
			end
			if (emit) begin
				n++;
				if (n > 1)
					expected_reports.push_back(held);
				held = r;
			end
		end
		if (n > 0) begin
			held.last = 1'b1;
			expected_reports.push_back(held);
		end
	endfunction

	function automatic string fmt_report(touch_report_t r);
		return $sformatf("slot %0d id %0d x %0d y %0d state %0d last %0d",
			r.slot, r.id, r.x, r.y, r.state, r.last);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ev_word_t word;
		if (!arst_n) begin
			event_valid <= 1'b0;
			event_type <= '0;
			event_code <= '0;
			event_value <= '0;
			tx_wait <= 0;
		end else begin
			if (event_valid && !event_stall)
				apply_event(event_type, event_code, event_value);
			if (!event_valid || !event_stall) begin
				if (tx_wait > 0) begin
					event_valid <= 1'b0;
					tx_wait <= tx_wait - 1;
				end else if (queued_events.size() > 0) begin
					word = queued_events.pop_front();
					event_type <= word.etype;
					event_code <= word.code;
					event_value <= word.value;
					event_valid <= 1'b1;
					tx_wait <= idle_on ? int'($urandom_range(0, 3)) : 0;
				end else begin
					event_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		touch_report_t got, want;
		int            wait_next;
		if (!arst_n) begin
			report_stall <= 1'b0;
			rx_wait <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			wait_next = rx_wait;
			if (report_valid && !report_stall) begin
				got.slot = slot_index;
				got.id = contact_id;
				got.x = x_out;
				got.y = y_out;
				got.state = touch_state;
				got.last = last_report;
				reports_seen++;
				if (expected_reports.size() == 0) begin
					errors++;
					$display("%0t: unexpected report, expected none, got %s", $time,
						fmt_report(got));
				end else begin
					want = expected_reports.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: report mismatch, expected %s, got %s", $time,
							fmt_report(want), fmt_report(got));
					end
				end
				wait_next = idle_on ? int'($urandom_range(0, 3)) : 0;
			end
			if (hold_req && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= LONG_HOLD;
				report_stall <= 1'b1;
				rx_wait <= wait_next;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				report_stall <= 1'b1;
				rx_wait <= wait_next;
			end else if (wait_next > 0) begin
				report_stall <= 1'b1;
				rx_wait <= wait_next - 1;
			end else begin
				report_stall <= 1'b0;
				rx_wait <= 0;
			end
		end
	end

	task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			CFG_ROT_MODE: rot_mode = data[2:0];
			CFG_X_ORIGIN: x_org = data[15:0];
			CFG_Y_ORIGIN: y_org = data[15:0];
			CFG_SPAN_W:   span_w = data;
			CFG_SPAN_H:   span_h = data;
			CFG_COS:      cos_q = data[15:0];
			CFG_SIN:      sin_q = data[15:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(logic [2:0] mode, int xo, int yo, int sw, int sh,
			int cs, int sn);
		set_register(CFG_ROT_MODE, CFG_DATA_W'(mode));
		set_register(CFG_X_ORIGIN, CFG_DATA_W'(xo));
		set_register(CFG_Y_ORIGIN, CFG_DATA_W'(yo));
		set_register(CFG_SPAN_W, CFG_DATA_W'(sw));
		set_register(CFG_SPAN_H, CFG_DATA_W'(sh));
		set_register(CFG_COS, CFG_DATA_W'(cs));
		set_register(CFG_SIN, CFG_DATA_W'(sn));
		n_settings++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (queued_events.size() != 0 || event_valid || expected_reports.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic put(logic [15:0] t, logic [15:0] c, logic [31:0] v, bit counts);
		ev_word_t word;
		word.etype = t;
		word.code = c;
		word.value = v;
		queued_events.push_back(word);
		if (counts)
			n_items++;
		else
			n_noise++;
		if (t == EV_ABS && c == CODE_SLOT) begin
			gen_sel = ($signed(v) >= 0 && $signed(v) < SLOTS);
			if (gen_sel)
				gen_slot = int'(v);
		end else if (t == EV_ABS && c == CODE_TRACK && gen_sel && !v[31]) begin
			touched[gen_slot] = 1'b1;
		end
	endtask

	function automatic logic [31:0] new_id();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'h7fff_ffff;
			default: return $urandom & 32'h7fff_ffff;
		endcase
	endfunction

	function automatic logic [31:0] pick_coord(logic [15:0] org, logic [16:0] span);
		int unsigned k, hi;
		k = $urandom_range(0, 9);
		hi = 32'(span_len(span) - 1);
		if (k < 7)
			return 32'(org) + $urandom_range(0, hi);
		if (k == 7)
			return $urandom_range(0, 65535);
		if (k == 8)
			return -$urandom_range(1, 1000);
		return $urandom;
	endfunction

	task automatic put_pos(logic [15:0] c);
		if (gen_sel && !touched[gen_slot])
			put(EV_ABS, CODE_TRACK, new_id(), 1'b1);
		if (c == CODE_POS_X)
			put(EV_ABS, c, pick_coord(x_org, span_w), 1'b1);
		else
			put(EV_ABS, c, pick_coord(y_org, span_h), 1'b1);
	endtask

	task automatic put_noise();
		logic [15:0] t;
		if ($urandom_range(0, 1)) begin
			t = 16'($urandom);
			if (t == EV_ABS)
				t = ~t;
			put(t, 16'($urandom), $urandom, 1'b0);
		end else begin
			put(EV_ABS, 16'($urandom) | 16'h0100, $urandom, 1'b0);
		end
	endtask

	task automatic send_frame();
		int          n, k;
		logic [31:0] sv;
		if ($urandom_range(0, 9) == 0) begin
			sv = $urandom_range(0, 1) ? ($urandom | 32'h8000_0000)
				: $urandom_range(SLOTS, 32'h7fff_ffff);
			put(EV_ABS, CODE_SLOT, sv, 1'b1);
			put_pos(CODE_POS_X);
		end
		n = $urandom_range(1, 4);
		for (k = 0; k < n; k++) begin
			put(EV_ABS, CODE_SLOT, $urandom_range(0, SLOTS - 1), 1'b1);
			case ($urandom_range(0, 7))
				0: put(EV_ABS, CODE_TRACK, $urandom | 32'h8000_0000, 1'b1);
				1, 2: begin
					put(EV_ABS, CODE_TRACK, new_id(), 1'b1);
					put_pos(CODE_POS_X);
					put_pos(CODE_POS_Y);
				end
				3: begin
					put(EV_ABS, CODE_TRACK, new_id(), 1'b1);
					put_pos($urandom_range(0, 1) ? CODE_POS_X : CODE_POS_Y);
				end
				default: begin
					if ($urandom_range(0, 1))
						put_pos(CODE_POS_X);
					if ($urandom_range(0, 1))
						put_pos(CODE_POS_Y);
				end
			endcase
			if ($urandom_range(0, 5) == 0)
				put_noise();
		end
		put(EV_SYNC, CODE_REPORT, $urandom, 1'b1);
	endtask

	initial begin
		int p, s, goal;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Opening sequence under reset settings: down, move, unchanged position, saturated
		// coordinates, out-of-range slot selection, lift of an idle slot, a down that lacks
		// an axis, and ups with missing axes.
		put(EV_ABS, CODE_SLOT, 32'd0, 1'b1);
		put(EV_ABS, CODE_TRACK, 32'd0, 1'b1);
		put(EV_ABS, CODE_POS_X, 32'd0, 1'b1);
		put(EV_ABS, CODE_POS_Y, 32'd65535, 1'b1);
		put(EV_SYNC, CODE_REPORT, 32'd0, 1'b1);
		put(EV_ABS, CODE_POS_X, 32'd4095, 1'b1);
		put(EV_SYNC, CODE_REPORT, 32'd0, 1'b1);
		put(EV_SYNC, CODE_REPORT, 32'd0, 1'b1);
		put(EV_ABS, CODE_SLOT, 32'd15, 1'b1);
		put(EV_ABS, CODE_TRACK, 32'h7fff_ffff, 1'b1);
		put(EV_ABS, CODE_POS_X, -32'sd5, 1'b1);
		put(EV_ABS, CODE_POS_Y, 32'd70000, 1'b1);
		put(EV_SYNC, CODE_REPORT, 32'hffff_ffff, 1'b1);
		put(EV_ABS, CODE_SLOT, 32'hffff_ffff, 1'b1);
		put(EV_ABS, CODE_POS_X, 32'd123, 1'b1);
		put(EV_ABS, CODE_SLOT, 32'd16, 1'b1);
		put(EV_ABS, CODE_TRACK, 32'd7, 1'b1);
		put(EV_ABS, CODE_SLOT, 32'd1, 1'b1);
		put(EV_ABS, CODE_TRACK, 32'hffff_ffff, 1'b1);
		put(EV_ABS, CODE_TRACK, 32'h1234_5678, 1'b1);
		put(EV_ABS, CODE_POS_X, 32'd2000, 1'b1);
		put(EV_SYNC, CODE_REPORT, 32'd0, 1'b1);
		put(EV_ABS, CODE_TRACK, 32'hffff_ffff, 1'b1);
		put(EV_SYNC, CODE_REPORT, 32'd0, 1'b1);
		put(EV_ABS, CODE_SLOT, 32'd2, 1'b1);
		put(EV_ABS, CODE_TRACK, 32'd99, 1'b1);
		put(EV_ABS, CODE_TRACK, 32'h8000_0000, 1'b1);
		put(EV_ABS, CODE_SLOT, 32'd0, 1'b1);
		put(EV_ABS, CODE_TRACK, 32'hffff_fffe, 1'b1);
		put(EV_SYNC, 16'd1, 32'd0, 1'b0);
		put(EV_SYNC, CODE_REPORT, 32'd0, 1'b1);

		for (p = 1; p <= 9; p++) begin
			wait_idle();
			idle_on = (p % 3 != 2);
			case (p)
				1: apply_setting(ROT_90, 0, 0, 4096, 4096, 16384, 0);
				2: apply_setting(ROT_180, 100, 200, 1000, 600, 16384, 0);
				3: apply_setting(ROT_270, 65535, 65535, 65536, 65536, 0, 16384);
				4: apply_setting(ROT_ANY, 0, 0, 4096, 4096, 11585, 11585);
				5: apply_setting(ROT_ANY, 50, 0, 1, 131071, -16384, -16384);
				6: apply_setting(ROT_ANY, $urandom_range(0, 65535), $urandom_range(0, 65535),
					0, 2048, 16384, -16384);
				7: apply_setting(ROT_ANY + 3'($urandom_range(1, 3)), 300, 400, 2000, 3000,
					-11585, 11585);
				8: apply_setting(ROT_ANY, $urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(1, 65536), $urandom_range(1, 65536),
					int'($urandom_range(0, 32768)) - 16384,
					int'($urandom_range(0, 32768)) - 16384);
				default: apply_setting(ROT_NONE, 300, 400, 2000, 2000,
					int'($urandom_range(0, 32768)) - 16384, 0);
			endcase
			if (p == 3) begin
				// Every slot goes down in one report, then every slot is sent a new X position for the next.
				hold_req = 1'b1;
				for (s = 0; s < SLOTS; s++) begin
					put(EV_ABS, CODE_SLOT, s, 1'b1);
					put(EV_ABS, CODE_TRACK, new_id(), 1'b1);
					put_pos(CODE_POS_X);
					put_pos(CODE_POS_Y);
				end
				put(EV_SYNC, CODE_REPORT, 32'd0, 1'b1);
				for (s = 0; s < SLOTS; s++) begin
					put(EV_ABS, CODE_SLOT, s, 1'b1);
					put_pos(CODE_POS_X);
				end
				put(EV_SYNC, CODE_REPORT, 32'd0, 1'b1);
			end
			goal = n_items + 18;
			while (n_items < goal)
				send_frame();
		end
		wait_idle();

		$display("Sent %0d event words plus %0d ignored ones under %0d register settings,",
			n_items, n_noise, n_settings);
		$display("checked %0d reports, including a %0d-cycle hold on the report side.",
			reports_seen, LONG_HOLD);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d words queued and %0d reports outstanding.",
			queued_events.size(), expected_reports.size());
		$display("status: fail");
		$finish;
	end

endmodule
